[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/tsd_pkg.sv]
// Types, constants and helpers for the tar stream deframer.
package tsd_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BO_W        = $clog2(BLOCK_BYTES);
  localparam int SIZE_DIGITS = 12;
  localparam int ACC_W       = 36;
  localparam int CNT_W       = ACC_W + 1;
  localparam int MODE_W      = 9;

  localparam logic [BO_W-1:0] MODE_FIRST  = BO_W'(100);
  localparam logic [BO_W-1:0] MODE_LAST   = BO_W'(107);
  localparam logic [BO_W-1:0] SIZE_FIRST  = BO_W'(124);
  localparam logic [BO_W-1:0] SIZE_LAST   = BO_W'(124 + SIZE_DIGITS - 1);
  localparam logic [BO_W-1:0] TIME_FIRST  = BO_W'(136);
  localparam logic [BO_W-1:0] TIME_LAST   = BO_W'(147);
  localparam logic [BO_W-1:0] TYPE_OFF    = BO_W'(156);
  localparam logic [BO_W-1:0] BLOCK_LAST  = BO_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [MODE_W-1:0] EXEC_MASK = 9'o111;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_END,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    FS_LEAD,
    FS_DIGITS,
    FS_TRAIL,
    FS_DONE
  } field_state_t;

  typedef struct packed {
    field_state_t fs;
    logic         take;
    logic         err;
  } field_step_t;

  function automatic logic is_regular_type(input logic [7:0] t);
    return (t == CHAR_ZERO) || (t == CHAR_NUL) || (t == CHAR_SEVEN);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_odigit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  // One byte of an octal field: next parse state, digit taken, error seen.
  function automatic field_step_t field_step(input field_state_t fs, input logic [7:0] c);
    field_step_t r;
    r.fs   = fs;
    r.take = 1'b0;
    r.err  = 1'b0;
    case (fs)
      FS_LEAD: begin
        if (is_ws(c)) begin
        end else if (is_odigit(c)) begin
          r.fs   = FS_DIGITS;
          r.take = 1'b1;
        end else if (c == CHAR_NUL) begin
          r.fs = FS_DONE;
        end else begin
          r.fs  = FS_DONE;
          r.err = 1'b1;
        end
      end
      FS_DIGITS: begin
        if (is_odigit(c)) begin
          r.take = 1'b1;
        end else if (is_ws(c)) begin
          r.fs = FS_TRAIL;
        end else if (c == CHAR_NUL) begin
          r.fs = FS_DONE;
        end else begin
          r.fs  = FS_DONE;
          r.err = 1'b1;
        end
      end
      FS_TRAIL: begin
        if (is_ws(c)) begin
        end else if (c == CHAR_NUL) begin
          r.fs = FS_DONE;
        end else begin
          r.fs  = FS_DONE;
          r.err = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

[design/tar_stream_deframer_unit.sv]
// Tar stream deframer top level: header parsing and member data pass-through.
// A request enters the input register, and its result (if any) is then
// registered in the output register.
// Throughput: one byte per cycle, sustained while the output side takes results.
// Reset (rst, synchronous, active high) returns to header phase at offset zero
// and empties both registers.
module tar_stream_deframer_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               data_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               kind,
  output logic [7:0]               out_byte,
  output logic                     last_byte,
  output logic [tsd_pkg::ACC_W-1:0] member_size,
  output logic                     executable,
  output logic [tsd_pkg::ACC_W-1:0] mod_time,
  output logic                     is_regular,
  output logic [7:0]               type_code
);

  logic                        in_full;
  logic [7:0]                  in_byte;
  logic                        advance;
  logic                        step;

  tsd_pkg::phase_t             phase, phase_next;
  logic [tsd_pkg::BO_W-1:0]    block_offset, block_offset_next;
  tsd_pkg::field_state_t       field_state, field_state_next;
  logic [tsd_pkg::ACC_W-1:0]   size_accum, size_accum_next;
  logic [tsd_pkg::MODE_W-1:0]  mode_accum, mode_accum_next;
  logic [tsd_pkg::ACC_W-1:0]   time_accum, time_accum_next;
  logic                        name_empty, name_empty_next;
  logic                        field_error, field_error_next;
  logic [7:0]                  saved_type, saved_type_next;
  logic [tsd_pkg::CNT_W-1:0]   bytes_consumed, bytes_consumed_next;

  logic                        res_vld;
  logic [1:0]                  res_kind;
  logic [7:0]                  res_byte;
  logic                        res_last;
  logic [tsd_pkg::ACC_W-1:0]   res_size;
  logic                        res_exec;
  logic [tsd_pkg::ACC_W-1:0]   res_time;
  logic                        res_reg;
  logic [7:0]                  res_type;

  logic [tsd_pkg::CNT_W-1:0]   size_ext;
  logic [tsd_pkg::CNT_W-1:0]   bc_inc;
  logic [tsd_pkg::BO_W-1:0]    off_inc;
  tsd_pkg::field_state_t       fs_cur;
  tsd_pkg::field_step_t        fstep;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;
  assign step     = in_full && advance;
  assign size_ext = {1'b0, size_accum};
  assign bc_inc   = bytes_consumed + tsd_pkg::CNT_W'(1);
  assign off_inc  = block_offset + tsd_pkg::BO_W'(1);
  // each numeric field starts in leading whitespace
  assign fs_cur   = ((block_offset == tsd_pkg::MODE_FIRST) ||
                     (block_offset == tsd_pkg::SIZE_FIRST) ||
                     (block_offset == tsd_pkg::TIME_FIRST)) ? tsd_pkg::FS_LEAD : field_state;
  assign fstep    = tsd_pkg::field_step(fs_cur, in_byte);

  always_comb begin
    phase_next          = phase;
    block_offset_next   = block_offset;
    field_state_next    = field_state;
    size_accum_next     = size_accum;
    mode_accum_next     = mode_accum;
    time_accum_next     = time_accum;
    name_empty_next     = name_empty;
    field_error_next    = field_error;
    saved_type_next     = saved_type;
    bytes_consumed_next = bytes_consumed;
    res_vld  = 1'b0;
    res_kind = tsd_pkg::KIND_DATA;
    res_byte = '0;
    res_last = 1'b0;
    res_size = '0;
    res_exec = 1'b0;
    res_time = '0;
    res_reg  = 1'b0;
    res_type = '0;

    unique case (phase)
      tsd_pkg::PH_DATA: begin
        if ((bytes_consumed < size_ext) && tsd_pkg::is_regular_type(saved_type)) begin
          res_vld  = 1'b1;
          res_kind = tsd_pkg::KIND_DATA;
          res_byte = in_byte;
          res_last = (bc_inc == size_ext);
        end
        bytes_consumed_next = bc_inc;
        block_offset_next   = off_inc;
        if ((bc_inc >= size_ext) && (off_inc == '0)) begin
          phase_next          = tsd_pkg::PH_HEADER;
          bytes_consumed_next = '0;
        end
      end
      tsd_pkg::PH_HEADER: begin
        if (block_offset == '0) begin
          size_accum_next  = '0;
          mode_accum_next  = '0;
          time_accum_next  = '0;
          field_error_next = 1'b0;
          saved_type_next  = '0;
          name_empty_next  = (in_byte == tsd_pkg::CHAR_NUL);
        end
        if ((block_offset == tsd_pkg::MODE_FIRST) || (block_offset == tsd_pkg::SIZE_FIRST) ||
            (block_offset == tsd_pkg::TIME_FIRST)) begin
          field_state_next = tsd_pkg::FS_LEAD;
        end

        if ((block_offset >= tsd_pkg::MODE_FIRST) && (block_offset <= tsd_pkg::MODE_LAST)) begin
          if (fstep.take) mode_accum_next = {mode_accum[tsd_pkg::MODE_W-4:0], in_byte[2:0]};
          if (fstep.err) field_error_next = 1'b1;
          field_state_next = fstep.fs;
        end else if ((block_offset >= tsd_pkg::SIZE_FIRST) &&
                     (block_offset <= tsd_pkg::SIZE_LAST)) begin
          if (fstep.take) size_accum_next = {size_accum[tsd_pkg::ACC_W-4:0], in_byte[2:0]};
          if (fstep.err) field_error_next = 1'b1;
          field_state_next = fstep.fs;
        end else if ((block_offset >= tsd_pkg::TIME_FIRST) &&
                     (block_offset <= tsd_pkg::TIME_LAST)) begin
          if (fstep.take) time_accum_next = {time_accum[tsd_pkg::ACC_W-4:0], in_byte[2:0]};
          if (fstep.err) field_error_next = 1'b1;
          field_state_next = fstep.fs;
        end else if (block_offset == tsd_pkg::TYPE_OFF) begin
          saved_type_next = in_byte;
        end

        if (block_offset != tsd_pkg::BLOCK_LAST) begin
          block_offset_next = off_inc;
        end else begin
          block_offset_next   = '0;
          field_state_next    = tsd_pkg::FS_LEAD;
          bytes_consumed_next = '0;
          res_vld             = 1'b1;
          if (name_empty_next) begin
            phase_next = tsd_pkg::PH_END;
            res_kind   = tsd_pkg::KIND_END;
          end else if (field_error_next) begin
            phase_next = tsd_pkg::PH_ERROR;
            res_kind   = tsd_pkg::KIND_ERROR;
          end else begin
            res_kind   = tsd_pkg::KIND_HEADER;
            res_size   = size_accum_next;
            res_exec   = |(mode_accum_next & tsd_pkg::EXEC_MASK);
            res_time   = time_accum_next;
            res_reg    = tsd_pkg::is_regular_type(saved_type_next);
            res_type   = saved_type_next;
            phase_next = (size_accum_next != '0) ? tsd_pkg::PH_DATA : tsd_pkg::PH_HEADER;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= tsd_pkg::PH_HEADER;
      block_offset   <= '0;
      field_state    <= tsd_pkg::FS_LEAD;
      size_accum     <= '0;
      mode_accum     <= '0;
      time_accum     <= '0;
      name_empty     <= 1'b0;
      field_error    <= 1'b0;
      saved_type     <= '0;
      bytes_consumed <= '0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (advance) out_valid <= step && res_vld;
      if (step) begin
        phase          <= phase_next;
        block_offset   <= block_offset_next;
        field_state    <= field_state_next;
        size_accum     <= size_accum_next;
        mode_accum     <= mode_accum_next;
        time_accum     <= time_accum_next;
        name_empty     <= name_empty_next;
        field_error    <= field_error_next;
        saved_type     <= saved_type_next;
        bytes_consumed <= bytes_consumed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= data_byte;
    if (step && res_vld) begin
      kind        <= res_kind;
      out_byte    <= res_byte;
      last_byte   <= res_last;
      member_size <= res_size;
      executable  <= res_exec;
      mod_time    <= res_time;
      is_regular  <= res_reg;
      type_code   <= res_type;
    end
  end

endmodule

[design/tsd_checker.sv]
// Port-level checker for the tar stream deframer, bound to the top level.
`include "assert_macros.svh"

module tsd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                kind,
  input logic [7:0]                out_byte,
  input logic                      last_byte,
  input logic [tsd_pkg::ACC_W-1:0] member_size,
  input logic                      executable,
  input logic                      is_regular,
  input logic [7:0]                type_code
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(kind))
  `ASSERT_IMPL(a_data_clean, clk, rst, out_valid && (kind == tsd_pkg::KIND_DATA), (member_size == '0) && !executable && (type_code == '0) && !is_regular)
  `ASSERT_IMPL(a_hdr_clean, clk, rst, out_valid && (kind != tsd_pkg::KIND_DATA), !last_byte && (out_byte == '0))
  `ASSERT_IMPL(a_regular, clk, rst, out_valid && (kind == tsd_pkg::KIND_HEADER), is_regular == tsd_pkg::is_regular_type(type_code))
  `ASSERT_NEXT(a_stop, clk, rst, out_valid && out_ready && ((kind == tsd_pkg::KIND_END) || (kind == tsd_pkg::KIND_ERROR)), !out_valid)

endmodule

bind tar_stream_deframer_unit tsd_checker u_tsd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .out_byte    (out_byte),
  .last_byte   (last_byte),
  .member_size (member_size),
  .executable  (executable),
  .is_regular  (is_regular),
  .type_code   (type_code)
);
